FILE: src/b64_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and alphabet functions of the base64 codec.
// ----------------------------------------------------------------------------
package b64_pkg;

    localparam int unsigned B64_FIFO_DEPTH = 2;

    localparam logic        MODE_ENCODE = 1'b0;
    localparam logic        MODE_DECODE = 1'b1;

    localparam logic [7:0]  PAD_CHAR    = 8'h3D;

    // One accepted input item turned into up to four result items.
    typedef struct packed {
        logic [31:0] bytes;     // first result in the low byte
        logic [2:0]  cnt;       // number of results, 1 to 4
        logic        data_ok;   // clear only for a bare end marker
        logic        last;
        logic        stopped;
    } t_job;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        begin
            w = {2'b00, v};
            if (v < 6'd26) begin
                b64_char = w + 8'h41;
            end else if (v < 6'd52) begin
                b64_char = w + 8'h47;
            end else if (v < 6'd62) begin
                b64_char = w - 8'h04;
            end else if (v == 6'd62) begin
                b64_char = 8'h2B;
            end else begin
                b64_char = 8'h2F;
            end
        end
    endfunction

    // Returns {valid, sextet}.
    function automatic logic [6:0] b64_sextet(input logic [7:0] c);
        logic [7:0] t;
        begin
            t = 8'h00;
            if (c >= 8'h41 && c <= 8'h5A) begin
                t = c - 8'h41;
                b64_sextet = {1'b1, t[5:0]};
            end else if (c >= 8'h61 && c <= 8'h7A) begin
                t = c - 8'h47;
                b64_sextet = {1'b1, t[5:0]};
            end else if (c >= 8'h30 && c <= 8'h39) begin
                t = c + 8'h04;
                b64_sextet = {1'b1, t[5:0]};
            end else if (c == 8'h2B) begin
                b64_sextet = {1'b1, 6'd62};
            end else if (c == 8'h2F) begin
                b64_sextet = {1'b1, 6'd63};
            end else begin
                b64_sextet = {1'b0, t[5:0]};
            end
        end
    endfunction

endpackage

FILE: src/b64_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_front
// Accepts input transactions, tracks the group state and builds result jobs.
// ----------------------------------------------------------------------------
module b64_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_wr_data,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    input  logic          i_has_byte,
    input  logic          i_last,
    output logic          o_push,
    output b64_pkg::t_job o_job
);
    import b64_pkg::*;

    logic        r_mode;
    logic [23:0] r_bits;
    logic [1:0]  r_cnt;
    logic        r_halt;

    logic [23:0] n_bits;
    logic [1:0]  n_cnt;
    logic        n_halt;

    logic [23:0] e_bits;
    logic [1:0]  e_cnt;
    logic [17:0] d_low;
    logic [6:0]  sx;
    t_job        job;

    always_comb begin
        n_bits       = r_bits;
        n_cnt        = r_cnt;
        n_halt       = r_halt;
        e_bits       = {r_bits[15:0], i_byte};
        e_cnt        = r_cnt + 2'd1;
        d_low        = r_bits[17:0];
        sx           = b64_sextet(i_byte);
        job.bytes    = 32'h0;
        job.cnt      = 3'd0;
        job.data_ok  = 1'b1;
        job.last     = i_last;
        job.stopped  = 1'b0;

        if (r_mode == MODE_ENCODE) begin
            if (i_has_byte) begin
                n_bits = e_bits;
                n_cnt  = e_cnt;
                if (e_cnt == 2'd3) begin
                    job.bytes = {b64_char(e_bits[5:0]),   b64_char(e_bits[11:6]),
                                 b64_char(e_bits[17:12]), b64_char(e_bits[23:18])};
                    job.cnt   = 3'd4;
                    n_bits    = 24'h0;
                    n_cnt     = 2'd0;
                end
            end
            if (i_last) begin
                if (n_cnt == 2'd1) begin
                    job.bytes = {PAD_CHAR, PAD_CHAR,
                                 b64_char({n_bits[1:0], 4'b0000}),
                                 b64_char(n_bits[7:2])};
                    job.cnt   = 3'd4;
                end else if (n_cnt == 2'd2) begin
                    job.bytes = {PAD_CHAR,
                                 b64_char({n_bits[3:0], 2'b00}),
                                 b64_char(n_bits[9:4]),
                                 b64_char(n_bits[15:10])};
                    job.cnt   = 3'd4;
                end
            end
        end else begin
            if (i_has_byte && !r_halt) begin
                if (!sx[6]) begin
                    n_halt = 1'b1;
                end else begin
                    n_bits = {d_low, sx[5:0]};
                    if (r_cnt == 2'd3) begin
                        job.bytes = {8'h00, n_bits[7:0], n_bits[15:8], n_bits[23:16]};
                        job.cnt   = 3'd3;
                        n_bits    = 24'h0;
                        n_cnt     = 2'd0;
                    end else begin
                        n_cnt = r_cnt + 2'd1;
                    end
                end
            end
            if (i_last) begin
                if (n_cnt == 2'd2) begin
                    job.bytes = {24'h0, n_bits[11:4]};
                    job.cnt   = 3'd1;
                end else if (n_cnt == 2'd3) begin
                    job.bytes = {16'h0, n_bits[9:2], n_bits[17:10]};
                    job.cnt   = 3'd2;
                end
            end
            job.stopped = n_halt;
        end

        if (i_last && job.cnt == 3'd0) begin
            job.bytes   = 32'h0;
            job.cnt     = 3'd1;
            job.data_ok = 1'b0;
        end
        if (i_last) begin
            n_bits = 24'h0;
            n_cnt  = 2'd0;
            n_halt = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENCODE;
            r_bits <= 24'h0;
            r_cnt  <= 2'd0;
            r_halt <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
            r_bits <= 24'h0;
            r_cnt  <= 2'd0;
            r_halt <= 1'b0;
        end else if (i_accept) begin
            r_bits <= n_bits;
            r_cnt  <= n_cnt;
            r_halt <= n_halt;
        end
    end

    assign o_push = i_accept && (job.cnt != 3'd0);
    assign o_job  = job;

endmodule

FILE: src/b64_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_fifo
// Short job queue between the front and back parts of the codec.
// ----------------------------------------------------------------------------
module b64_fifo #(
    parameter int unsigned DEPTH = b64_pkg::B64_FIFO_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  b64_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output b64_pkg::t_job o_job
);
    import b64_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: src/b64_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_back
// Unpacks queued jobs into one output transaction per cycle while i_tready allows.
// ----------------------------------------------------------------------------
module b64_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  b64_pkg::t_job i_job,
    output logic          o_job_pop,
    output logic          o_tvalid,
    input  logic          i_tready,
    output logic [7:0]    o_tdata,
    output logic [1:0]    o_tuser,
    output logic          o_tlast
);
    import b64_pkg::*;

    logic        r_busy;
    logic [31:0] r_bytes;
    logic [2:0]  r_left;
    logic        r_dok;
    logic        r_last;
    logic        r_stop;

    logic        r_ovalid;
    logic [7:0]  r_odata;
    logic [1:0]  r_ouser;
    logic        r_olast;

    logic        out_free;
    logic        emit;
    logic        final_one;
    logic        take;

    assign out_free  = !r_ovalid || i_tready;
    assign emit      = r_busy && out_free;
    assign final_one = (r_left == 3'd1);
    assign take      = i_job_valid && (!r_busy || (emit && final_one));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (out_free) begin
                r_ovalid <= 1'b0;
            end
            if (take) begin
                r_busy <= 1'b1;
            end else if (emit && final_one) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_odata <= r_bytes[7:0];
            r_ouser <= {r_stop, r_dok};
            r_olast <= r_last && final_one;
            r_bytes <= {8'h00, r_bytes[31:8]};
            r_left  <= r_left - 3'd1;
        end
        if (take) begin
            r_bytes <= i_job.bytes;
            r_left  <= i_job.cnt;
            r_dok   <= i_job.data_ok;
            r_last  <= i_job.last;
            r_stop  <= i_job.stopped;
        end
    end

    assign o_job_pop = take;
    assign o_tvalid  = r_ovalid;
    assign o_tdata   = r_odata;
    assign o_tuser   = r_ouser;
    assign o_tlast   = r_olast;

endmodule

FILE: src/base64_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_codec
// Streaming base64 encoder and decoder with the standard alphabet.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one byte or character per transaction; tuser flags that
//   tdata holds a byte, tlast closes the message. m_axis returns encoded
//   characters or decoded bytes; tuser[0] marks data (clear on a bare end
//   marker), tuser[1] reports a decode stop, tlast ends the message.
//   i_cfg_wr_en writes the mode (0 encode, 1 decode) and starts a new
//   message; write it only while the codec is idle.
//   The front takes one input transaction per cycle while the job queue
//   has room; the back sends one result per cycle while m_axis is ready.
//   An input's first result passes the job queue, the back's job register
//   and its output register. Encoding yields four characters per three
//   bytes, so m_axis sets its pace; decoding keeps up with one input per cycle.
//   Reset clears the mode to encode and empties queue and group state.
//   A stalled m_axis holds its transaction; the queue fills, then
//   s_axis_tready drops.
// ----------------------------------------------------------------------------
module base64_codec #(
    parameter int unsigned FIFO_DEPTH = b64_pkg::B64_FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tuser,   // [0] has_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [0] out_valid, [1] stopped
    output logic       m_axis_tlast
);
    import b64_pkg::*;

    logic accept;
    logic push;
    logic full;
    logic q_valid;
    logic pop;
    t_job f_job;
    t_job q_job;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && !full;

    b64_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_accept     (accept),
        .i_byte       (s_axis_tdata),
        .i_has_byte   (s_axis_tuser),
        .i_last       (s_axis_tlast),
        .o_push       (push),
        .o_job        (f_job)
    );

    b64_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (f_job),
        .o_full (full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_job  (q_job)
    );

    b64_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(q_valid),
        .i_job      (q_job),
        .o_job_pop  (pop),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_tdata    (m_axis_tdata),
        .o_tuser    (m_axis_tuser),
        .o_tlast    (m_axis_tlast)
    );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the streaming base64 codec.
// ----------------------------------------------------------------------------
// Drives byte and character transactions through s_axis in both modes and
// predicts every m_axis transaction with a scoreboard that encodes and
// decodes independently of the block. The scoreboard tracks the group being
// gathered, the decode stop flag and the mode. A directed part covers the
// edge values, padding, stops, bare ends, empty transactions and mode
// writes in the middle of a message. The random part alternates the modes
// and sends mostly well-formed messages with some noise. Both ports idle at
// random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
    import b64_pkg::*;

    localparam int RANDOM_ITEMS = 360;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 200;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
        logic       stopped;
    } t_codec_result;

    class codec_scoreboard;
        logic          mode;
        logic [23:0]   group_bits;
        logic [1:0]    group_count;
        logic          halted;
        string         alphabet;
        t_codec_result expected_q[$];
        t_codec_result fresh[$];
        int            mismatches;

        function new();
            alphabet    = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            mode        = MODE_ENCODE;
            group_bits  = '0;
            group_count = '0;
            halted      = 1'b0;
            mismatches  = 0;
        endfunction

        function logic [7:0] char_of(logic [5:0] v);
            return alphabet[v];
        endfunction

        function int sextet_of(logic [7:0] c);
            for (int i = 0; i < 64; i++) begin
                if (8'(alphabet[i]) == c) begin
                    return i;
                end
            end
            return -1;
        endfunction

        function void set_mode(logic m);
            mode        = m;
            group_bits  = '0;
            group_count = '0;
            halted      = 1'b0;
        endfunction

        function void put(logic [7:0] b);
            fresh.push_back('{out_byte: b, out_valid: 1'b1, out_last: 1'b0, stopped: 1'b0});
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Returns 1 when the transaction has any effect on the codec.
        function bit note_input(logic [7:0] b, logic has, logic fin);
            int v;
            bit useful;
            useful = fin || (has && !(mode == MODE_DECODE && halted));
            fresh.delete();
            if (mode == MODE_ENCODE) begin
                if (has) begin
                    group_bits  = {group_bits[15:0], b};
                    group_count = group_count + 2'd1;
                    if (group_count == 2'd3) begin
                        put(char_of(group_bits[23:18]));
                        put(char_of(group_bits[17:12]));
                        put(char_of(group_bits[11:6]));
                        put(char_of(group_bits[5:0]));
                        group_bits  = '0;
                        group_count = '0;
                    end
                end
                if (fin && group_count == 2'd1) begin
                    put(char_of(group_bits[7:2]));
                    put(char_of({group_bits[1:0], 4'b0000}));
                    put(PAD_CHAR);
                    put(PAD_CHAR);
                end else if (fin && group_count == 2'd2) begin
                    put(char_of(group_bits[15:10]));
                    put(char_of(group_bits[9:4]));
                    put(char_of({group_bits[3:0], 2'b00}));
                    put(PAD_CHAR);
                end
            end else begin
                if (has && !halted) begin
                    v = sextet_of(b);
                    if (v < 0) begin
                        halted = 1'b1;
                    end else begin
                        group_bits = {group_bits[17:0], 6'(v)};
                        if (group_count == 2'd3) begin
                            put(group_bits[23:16]);
                            put(group_bits[15:8]);
                            put(group_bits[7:0]);
                            group_bits  = '0;
                            group_count = '0;
                        end else begin
                            group_count = group_count + 2'd1;
                        end
                    end
                end
                if (fin && group_count == 2'd2) begin
                    put(group_bits[11:4]);
                end else if (fin && group_count == 2'd3) begin
                    put(group_bits[17:10]);
                    put(group_bits[9:2]);
                end
                foreach (fresh[i]) begin
                    fresh[i].stopped = halted;
                end
            end
            if (fin) begin
                if (fresh.size() == 0) begin
                    fresh.push_back('{out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b0,
                                      stopped: (mode == MODE_DECODE) && halted});
                end
                fresh[fresh.size() - 1].out_last = 1'b1;
                group_bits  = '0;
                group_count = '0;
                halted      = 1'b0;
            end
            foreach (fresh[i]) begin
                expected_q.push_back(fresh[i]);
            end
            return useful;
        endfunction

        function void check_result(logic [7:0] b, logic [1:0] user, logic lst);
            t_codec_result want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display({"ERROR: unexpected transaction ",
                              "byte=%02h valid=%0b stopped=%0b last=%0b"},
                             b, user[0], user[1], lst);
                end
                return;
            end
            want = expected_q.pop_front();
            if (want.out_byte !== b || want.out_valid !== user[0] ||
                want.stopped !== user[1] || want.out_last !== lst) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display({"ERROR: expected byte=%02h valid=%0b stopped=%0b last=%0b, ",
                              "got byte=%02h valid=%0b stopped=%0b last=%0b"},
                             want.out_byte, want.out_valid, want.stopped, want.out_last,
                             b, user[0], user[1], lst);
                end
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_wr_en = 1'b0;
    logic       i_cfg_wr_data = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic       s_axis_tuser = 1'b0;    // [0] has_byte
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic [1:0] m_axis_tuser;           // [0] out_valid, [1] stopped
    logic       m_axis_tlast;

    codec_scoreboard sb;
    bit              no_idle = 1'b0;
    int              items_done = 0;
    int              results_seen = 0;
    int              cycles = 0;

    base64_codec dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            results_seen++;
        end
    end

    initial begin : receiver
        int hold;
        bit held;
        hold = 0;
        held = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 25);
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic has, input logic fin);
        while (!no_idle && $urandom_range(0, 99) < 25) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= has;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        if (sb.note_input(b, has, fin)) begin
            items_done++;
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_mode(m);
    endtask

    function automatic logic [7:0] rand_invalid();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (sb.sextet_of(c) >= 0);
        return c;
    endfunction

    task automatic rand_encode_msg();
        int n;
        logic fin;
        logic has;
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
            fin = (i == n - 1);
            has = fin ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 19) != 0);
            send_item(8'($urandom_range(0, 255)), has, fin);
        end
    endtask

    task automatic rand_decode_msg();
        int n;
        int kind;
        int bad_at;
        int pads;
        bit bare;
        logic [7:0] c;
        n      = $urandom_range(1, 12);
        kind   = $urandom_range(0, 9);
        bad_at = (kind == 9) ? $urandom_range(0, n - 1) : -1;
        pads   = 0;
        if (kind < 7 && (n % 4) >= 2 && $urandom_range(0, 1) == 1) begin
            pads = 4 - n % 4;
        end
        bare = (pads == 0) && ($urandom_range(0, 9) == 0);
        for (int i = 0; i < n; i++) begin
            if (kind == 7 || kind == 8) begin
                c = 8'($urandom_range(0, 255));
            end else if (i == bad_at) begin
                c = rand_invalid();
            end else begin
                c = sb.char_of(6'($urandom_range(0, 63)));
            end
            send_item(c, 1'b1, pads == 0 && !bare && i == n - 1);
        end
        for (int i = 0; i < pads; i++) begin
            send_item(PAD_CHAR, 1'b1, i == pads - 1);
        end
        if (bare) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_mode(MODE_ENCODE);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h01, 1'b1, 1'b1);
        send_item(8'hFE, 1'b1, 1'b0);
        send_item(8'h7F, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h55, 1'b0, 1'b0);
        send_item(8'h12, 1'b1, 1'b0);
        send_item(8'h34, 1'b1, 1'b0);
        send_item(8'h56, 1'b1, 1'b1);
        send_item(8'h9A, 1'b1, 1'b0);
        send_item(8'hAA, 1'b0, 1'b1);
        send_item(8'hAB, 1'b1, 1'b0);
        send_item(8'hCD, 1'b1, 1'b0);
        drain();

        write_mode(MODE_DECODE);
        send_item("T", 1'b1, 1'b0);
        send_item("W", 1'b1, 1'b0);
        send_item("F", 1'b1, 1'b0);
        send_item("u", 1'b1, 1'b0);
        send_item("Q", 1'b1, 1'b0);
        send_item("Q", 1'b1, 1'b0);
        send_item(PAD_CHAR, 1'b1, 1'b0);
        send_item(PAD_CHAR, 1'b1, 1'b1);
        send_item("A", 1'b1, 1'b1);
        send_item("/", 1'b1, 1'b0);
        send_item("+", 1'b1, 1'b0);
        send_item("9", 1'b1, 1'b0);
        send_item("z", 1'b1, 1'b0);
        send_item("a", 1'b1, 1'b0);
        send_item("Z", 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item("A", 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b0);
        send_item("A", 1'b1, 1'b0);
        send_item("B", 1'b1, 1'b0);
        send_item("!", 1'b1, 1'b0);
        drain();
        write_mode(MODE_DECODE);
        send_item("A", 1'b1, 1'b0);
        send_item("A", 1'b1, 1'b0);
        send_item("A", 1'b1, 1'b1);

        items_done = 0;
        for (int phase = 0; phase < 6; phase++) begin
            drain();
            write_mode((phase % 2 == 1) ? MODE_DECODE : MODE_ENCODE);
            no_idle = (phase == 2);
            while (items_done < (phase + 1) * RANDOM_ITEMS / 6) begin
                if (sb.mode == MODE_ENCODE) begin
                    rand_encode_msg();
                end else begin
                    rand_decode_msg();
                end
            end
        end
        no_idle = 1'b0;
        drain();

        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
